// ----- rtl/core/bsed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsed_pkg: shared constants for the braking and stop event detector
// Register indexes, field widths and fixed limits.
// ----------------------------------------------------------------------------
package bsed_pkg;
  localparam int PosBitsDefault = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_BRAKE_START = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BRAKE_END   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HARD        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EMERG       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_STOP_SPEED  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STOP_DUR    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COL_GAP     = 3'd6;

  localparam logic [19:0] AccLimit = 20'd1000000;
  localparam logic [9:0] TtcLimitS = 10'd999;
  localparam logic [9:0] Thousand = 10'd1000;

  // divider operation
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } bsed_div_req_t;
endpackage

// ----- rtl/core/bsed_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsed_div: serial restoring divider
// 32-bit unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module bsed_div (
  input  logic                   clk,
  input  logic                   rst,
  input  bsed_pkg::bsed_div_req_t req,
  output logic                   done,
  output logic [31:0]            quo
);
  import bsed_pkg::*;

  logic [31:0] rem;
  logic [31:0] num;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, num[31]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        rem <= '0;
        num <= req.num;
        den <= req.den;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], num[31]};
          quo <= {quo[30:0], 1'b0};
        end
        num <= {num[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/bsed_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsed_sqrt: serial integer square root
// 64-bit radicand, 32-bit root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bsed_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] n;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] shrem;
  logic [33:0] trial;

  assign shrem = {rem[31:0], n[63:62]};
  assign trial = shrem - {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        n <= rad;
        rem <= '0;
        root <= '0;
      end else if (busy) begin
        n <= {n[61:0], 2'b00};
        if (!trial[33]) begin
          rem <= trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem <= shrem;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/braking_and_stop_event_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// braking_and_stop_event_detector: braking episode and standstill detector
// Per active sample: acceleration, time to collision, episode distance,
// brake events and standstill collision.
// ----------------------------------------------------------------------------
// An active sample passes from acceptance through setup, the serial divider
// twice (acceleration, then time to collision), with the serial square root
// of the step length running alongside the first divide, a finishing step
// and the result beat, then returns to idle for the next acceptance. An
// inactive sample is taken while idle and gives no result. The result is
// held in an output register until taken; the next sample is accepted only
// after that.
module braking_and_stop_event_detector #(
  parameter int POS_BITS = bsed_pkg::PosBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsed_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bsed_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          vehicle_active,
  input  logic [31:0]                   time_ms,
  input  logic [16:0]                   speed,
  input  logic signed [POS_BITS-1:0]    pos_x,
  input  logic signed [POS_BITS-1:0]    pos_y,
  input  logic                          gap_valid,
  input  logic [19:0]                   leader_gap,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [20:0]            acceleration,
  output logic                          ttc_valid,
  output logic [19:0]                   ttc_ms,
  output logic                          in_episode,
  output logic [31:0]                   brake_distance,
  output logic                          hard_brake,
  output logic                          emergency_brake,
  output logic                          collision,
  output logic                          collision_latched
);
  import bsed_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_TTC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic signed [17:0] brake_start_accel, brake_end_accel, hard_brake_accel;
  logic signed [17:0] emergency_brake_accel;
  logic [16:0] stopped_speed;
  logic [31:0] stop_duration_ms;
  logic [19:0] collision_gap;

  // state
  logic [16:0] last_speed;
  logic        last_speed_valid;
  logic [31:0] last_time;
  logic        episode_active;
  logic [31:0] episode_distance;
  logic signed [20:0] episode_min_accel;
  logic signed [POS_BITS-1:0] last_x, last_y;
  logic hard_fired, emergency_fired, stop_start_valid, collision_flag;
  logic [31:0] stop_start_time;

  // sample latch
  logic [2:0]  state;
  logic [31:0] t_s;
  logic [16:0] spd_s;
  logic signed [POS_BITS-1:0] px_s, py_s;
  logic        gv_s;
  logic [19:0] gap_s;
  logic        acc_ok, acc_neg, sq_big, sqrt_pending, div_wait;
  logic [32:0] ax, ay;
  logic [63:0] sx, sy;
  logic [64:0] sum;
  logic signed [20:0] acc_r;
  logic [31:0] step_d;

  bsed_div_req_t div_req;
  logic        div_done;
  logic [31:0] div_quo;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  bsed_div u_div (.clk, .rst, .req(div_req), .done(div_done), .quo(div_quo));
  bsed_sqrt u_sqrt (.clk, .rst, .start(sq_start), .rad(sum[63:0]),
                    .done(sq_done), .root(sq_root));

  logic signed [POS_BITS:0] dx, dy;
  assign dx = {px_s[POS_BITS-1], px_s} - {last_x[POS_BITS-1], last_x};
  assign dy = {py_s[POS_BITS-1], py_s} - {last_y[POS_BITS-1], last_y};

  // magnitudes; bit 32 of ax/ay marks a step of 2^32 or more
  logic signed [63:0] dxw, dyw;
  logic [63:0] mx, my;
  assign dxw = 64'(dx);
  assign dyw = 64'(dy);
  assign mx = dxw[63] ? -dxw : dxw;
  assign my = dyw[63] ? -dyw : dyw;

  logic [16:0] dv;
  assign dv = acc_neg ? last_speed - spd_s : spd_s - last_speed;

  logic [26:0] ttc_lim;
  assign ttc_lim = 27'(spd_s) * 27'(TtcLimitS);
  logic ttc_ok;
  assign ttc_ok = gv_s && spd_s != '0 && 27'(gap_s) < ttc_lim;

  assign in_ready = (state == S_IDLE);

  // finishing step, combinational on the latched sample
  logic signed [20:0] min_n;
  logic [32:0] dist_sum;
  logic stopped;
  logic [31:0] sst;
  assign stopped = spd_s <= stopped_speed;
  assign min_n = (acc_r < episode_min_accel) ? acc_r : episode_min_accel;
  assign dist_sum = {1'b0, episode_distance} + {1'b0, step_d};
  assign sst = stop_start_valid ? stop_start_time : t_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_start_accel <= -18'sd500;
      brake_end_accel <= -18'sd200;
      hard_brake_accel <= -18'sd4000;
      emergency_brake_accel <= -18'sd7000;
      stopped_speed <= 17'd100;
      stop_duration_ms <= 32'd10000;
      collision_gap <= 20'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRAKE_START: brake_start_accel <= cfg_data[17:0];
        REG_BRAKE_END:   brake_end_accel <= cfg_data[17:0];
        REG_HARD:        hard_brake_accel <= cfg_data[17:0];
        REG_EMERG:       emergency_brake_accel <= cfg_data[17:0];
        REG_STOP_SPEED:  stopped_speed <= cfg_data[16:0];
        REG_STOP_DUR:    stop_duration_ms <= cfg_data[31:0];
        REG_COL_GAP:     collision_gap <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_req.start <= 1'b0;
      sq_start <= 1'b0;
      last_speed <= '0;
      last_speed_valid <= 1'b0;
      last_time <= '0;
      episode_active <= 1'b0;
      episode_distance <= '0;
      episode_min_accel <= '0;
      last_x <= '0;
      last_y <= '0;
      hard_fired <= 1'b0;
      emergency_fired <= 1'b0;
      stop_start_valid <= 1'b0;
      stop_start_time <= '0;
      collision_flag <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      sq_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && vehicle_active) begin
            t_s <= time_ms;
            spd_s <= speed;
            px_s <= pos_x;
            py_s <= pos_y;
            gv_s <= gap_valid;
            gap_s <= leader_gap;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // magnitudes; squares follow in S_ACC
          ax <= {|mx[63:32], mx[31:0]};
          ay <= {|my[63:32], my[31:0]};
          acc_ok <= last_speed_valid && t_s > last_time;
          acc_neg <= spd_s < last_speed;
          state <= S_ACC;
          div_wait <= 1'b0;
          sqrt_pending <= 1'b0;
        end
        S_ACC: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            sq_big <= ax[32] || ay[32];
            sx <= ax[31:0] * ax[31:0];
            sy <= ay[31:0] * ay[31:0];
            div_req.start <= 1'b1;
            div_req.num <= 32'(dv) * 32'(Thousand);
            div_req.den <= t_s - last_time;
            sqrt_pending <= 1'b1;
          end else begin
            if (sqrt_pending) begin
              sqrt_pending <= 1'b0;
              sum <= {1'b0, sx} + {1'b0, sy};
              sq_start <= 1'b1;
            end
            if (div_done) begin
              if (!acc_ok) acc_r <= '0;
              else if (div_quo > 32'(AccLimit))
                acc_r <= acc_neg ? -21'(AccLimit) : 21'(AccLimit);
              else acc_r <= acc_neg ? -21'(div_quo) : 21'(div_quo);
              div_req.start <= 1'b1;
              div_req.num <= 32'(gap_s) * 32'(Thousand);
              div_req.den <= 32'(spd_s);
              div_wait <= 1'b0;
              state <= S_TTC;
            end
          end
        end
        S_TTC: begin
          if (sq_done) begin
            step_d <= (sq_big || sum[64]) ? 32'hFFFF_FFFF : sq_root;
          end
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          acceleration <= acc_r;
          ttc_valid <= ttc_ok;
          ttc_ms <= ttc_ok ? div_quo[19:0] : '0;
          hard_brake <= 1'b0;
          emergency_brake <= 1'b0;
          last_speed <= spd_s;
          last_speed_valid <= 1'b1;
          last_time <= t_s;
          if (!episode_active) begin
            in_episode <= 1'b0;
            brake_distance <= '0;
            if (acc_r <= 21'(brake_start_accel) && !stopped) begin
              episode_active <= 1'b1;
              episode_distance <= '0;
              episode_min_accel <= acc_r;
              last_x <= px_s;
              last_y <= py_s;
              hard_fired <= 1'b0;
              emergency_fired <= 1'b0;
              in_episode <= 1'b1;
            end
          end else begin
            episode_distance <= dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
            last_x <= px_s;
            last_y <= py_s;
            episode_min_accel <= min_n;
            if (!hard_fired && min_n <= 21'(hard_brake_accel)) begin
              hard_fired <= 1'b1;
              hard_brake <= 1'b1;
            end
            if (!emergency_fired && min_n <= 21'(emergency_brake_accel)) begin
              emergency_fired <= 1'b1;
              emergency_brake <= 1'b1;
            end
            if (stopped || acc_r >= 21'(brake_end_accel)) begin
              episode_active <= 1'b0;
              in_episode <= 1'b0;
              brake_distance <= '0;
            end else begin
              in_episode <= 1'b1;
              brake_distance <= dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
            end
          end
          collision <= 1'b0;
          if (stopped) begin
            stop_start_valid <= 1'b1;
            stop_start_time <= sst;
            if (t_s >= sst && t_s - sst >= stop_duration_ms && gv_s &&
                gap_s <= collision_gap) begin
              collision_flag <= 1'b1;
              collision <= 1'b1;
              collision_latched <= 1'b1;
            end else begin
              collision_latched <= collision_flag;
            end
          end else begin
            stop_start_valid <= 1'b0;
            stop_start_time <= '0;
            collision_flag <= 1'b0;
            collision_latched <= 1'b0;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/tb_braking_and_stop_event_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_braking_and_stop_event_detector: self-checking bench for the detector
// Drives vehicle samples over valid/ready with random idling on both sides.
// A scoreboard predicts acceleration, time to collision, braking episodes and
// the standstill collision, then checks each output beat in order.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_braking_and_stop_event_detector;
  import bsed_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 200;
  localparam int RandomPerPhase = 270;

  typedef struct {
    logic               active;
    logic [31:0]        t;
    logic [16:0]        spd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               gv;
    logic [19:0]        gap;
  } sample_t;

  typedef struct {
    logic signed [20:0] acc;
    logic               ttc_ok;
    logic [19:0]        ttc;
    logic               episode;
    logic [31:0]        run_mm;
    logic               hard;
    logic               emerg;
    logic               col;
    logic               col_held;
  } outcome_t;

  class brake_scoreboard;
    longint start_acc, end_acc, hard_acc, emerg_acc;
    longint unsigned stop_spd, stop_dur, col_gap;
    longint unsigned last_spd, last_t, ep_len, stop_t;
    bit hist, episode, hard_done, emerg_done, stop_run, col_flag;
    longint min_acc, last_x, last_y;
    outcome_t pending[$];
    int errors;

    function new();
      start_acc = -500; end_acc = -200; hard_acc = -4000; emerg_acc = -7000;
      stop_spd = 100; stop_dur = 10000; col_gap = 1000;
      last_spd = 0; last_t = 0; ep_len = 0; stop_t = 0;
      hist = 0; episode = 0; hard_done = 0; emerg_done = 0;
      stop_run = 0; col_flag = 0; min_acc = 0; last_x = 0; last_y = 0;
      errors = 0;
    endfunction

    function longint sext18(logic [31:0] v);
      logic signed [17:0] s;
      s = v[17:0];
      return longint'(s);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
      case (idx)
        REG_BRAKE_START: start_acc = sext18(v);
        REG_BRAKE_END:   end_acc = sext18(v);
        REG_HARD:        hard_acc = sext18(v);
        REG_EMERG:       emerg_acc = sext18(v);
        REG_STOP_SPEED:  stop_spd = v[16:0];
        REG_STOP_DUR:    stop_dur = v;
        REG_COL_GAP:     col_gap = v[19:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root64(logic [63:0] n);
      logic [63:0] r, probe;
      r = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= r + probe) begin
          n = n - (r + probe);
          r = (r >> 1) + probe;
        end else begin
          r = r >> 1;
        end
        probe = probe >> 2;
      end
      return r;
    endfunction

    function longint unsigned step_length(longint dx, longint dy);
      longint unsigned ax, ay;
      logic [64:0] sum;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
      sum = 65'(ax * ax) + 65'(ay * ay);
      if (sum[64]) return 32'hFFFF_FFFF;
      return root64(sum[63:0]);
    endfunction

    function void note_sample(sample_t s);
      outcome_t e;
      longint acc, px, py;
      longint unsigned t, spd, gap, dt, dv, q;
      bit neg;
      if (!s.active) return;
      t = s.t; spd = s.spd; gap = s.gap;
      px = longint'(s.x); py = longint'(s.y);
      acc = 0;
      e.hard = 0; e.emerg = 0; e.col = 0; e.ttc_ok = 0; e.ttc = 0;
      if (hist && t > last_t) begin
        dt = t - last_t;
        neg = spd < last_spd;
        dv = neg ? last_spd - spd : spd - last_spd;
        q = dv * 1000 / dt;
        if (q > 1000000) q = 1000000;
        acc = neg ? -longint'(q) : longint'(q);
      end
      last_spd = spd; hist = 1; last_t = t;
      if (s.gv && spd != 0 && gap < 999 * spd) begin
        e.ttc_ok = 1;
        q = gap * 1000 / spd;
        e.ttc = q[19:0];
      end
      if (!episode) begin
        if (acc <= start_acc && spd > stop_spd) begin
          episode = 1; ep_len = 0; min_acc = acc;
          last_x = px; last_y = py;
          hard_done = 0; emerg_done = 0;
        end
      end else begin
        ep_len = ep_len + step_length(px - last_x, py - last_y);
        if (ep_len > 64'hFFFF_FFFF) ep_len = 64'hFFFF_FFFF;
        last_x = px; last_y = py;
        if (acc < min_acc) min_acc = acc;
        if (!hard_done && min_acc <= hard_acc) begin
          hard_done = 1; e.hard = 1;
        end
        if (!emerg_done && min_acc <= emerg_acc) begin
          emerg_done = 1; e.emerg = 1;
        end
        if (spd <= stop_spd || acc >= end_acc) episode = 0;
      end
      if (spd <= stop_spd) begin
        if (!stop_run) begin
          stop_run = 1; stop_t = t;
        end
        if (t >= stop_t && t - stop_t >= stop_dur && s.gv && gap <= col_gap) begin
          col_flag = 1; e.col = 1;
        end
      end else begin
        stop_run = 0; stop_t = 0; col_flag = 0;
      end
      e.acc = acc[20:0];
      e.episode = episode;
      e.run_mm = episode ? ep_len[31:0] : 32'd0;
      e.col_held = col_flag;
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task check_result(outcome_t r);
      outcome_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (r.acc !== e.acc) report("acceleration", r.acc, e.acc);
      if (r.ttc_ok !== e.ttc_ok) report("ttc_valid", r.ttc_ok, e.ttc_ok);
      if (r.ttc !== e.ttc) report("ttc_ms", r.ttc, e.ttc);
      if (r.episode !== e.episode) report("in_episode", r.episode, e.episode);
      if (r.run_mm !== e.run_mm) report("brake_distance", r.run_mm, e.run_mm);
      if (r.hard !== e.hard) report("hard_brake", r.hard, e.hard);
      if (r.emerg !== e.emerg) report("emergency_brake", r.emerg, e.emerg);
      if (r.col !== e.col) report("collision", r.col, e.col);
      if (r.col_held !== e.col_held) report("collision_latched", r.col_held, e.col_held);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic vehicle_active = 0;
  logic [31:0] time_ms = '0;
  logic [16:0] speed = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic gap_valid = 0;
  logic [19:0] leader_gap = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [20:0] acceleration;
  logic ttc_valid;
  logic [19:0] ttc_ms;
  logic in_episode;
  logic [31:0] brake_distance;
  logic hard_brake, emergency_brake, collision, collision_latched;

  braking_and_stop_event_detector dut (.*);

  always #2 clk = ~clk;

  brake_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  longint unsigned trip_t;
  int trip_spd;
  int trip_x, trip_y;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("braking_and_stop_event_detector verification failed");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    outcome_t r;
    if (!rst && out_valid && out_ready) begin
      r.acc = acceleration; r.ttc_ok = ttc_valid; r.ttc = ttc_ms;
      r.episode = in_episode; r.run_mm = brake_distance; r.hard = hard_brake;
      r.emerg = emergency_brake; r.col = collision; r.col_held = collision_latched;
      sb.check_result(r);
    end
  end

  // called at a falling edge, returns at a falling edge
  task send_sample(sample_t s);
    in_valid <= 1;
    vehicle_active <= s.active; time_ms <= s.t; speed <= s.spd;
    pos_x <= s.x; pos_y <= s.y; gap_valid <= s.gv; leader_gap <= s.gap;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task send_fields(bit a, longint unsigned t, int unsigned spd, int x, int y,
                   bit gv, int unsigned gap);
    sample_t s;
    s.active = a; s.t = 32'(t); s.spd = 17'(spd); s.x = x; s.y = y; s.gv = gv;
    s.gap = 20'(gap);
    send_sample(s);
  endtask

  // leaves the write enable high; write_all drops it after the last write
  task write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task write_all(int bs, int be, int hb, int eb, int unsigned ss,
                 longint unsigned sd, int unsigned cg);
    write_reg(REG_BRAKE_START, bs);
    write_reg(REG_BRAKE_END, be);
    write_reg(REG_HARD, hb);
    write_reg(REG_EMERG, eb);
    write_reg(REG_STOP_SPEED, ss);
    write_reg(REG_STOP_DUR, 32'(sd));
    write_reg(REG_COL_GAP, cg);
    cfg_we <= 0;
  endtask

  task wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s.active = 0; s.t = $urandom; s.spd = 17'($urandom); s.x = $urandom;
      s.y = $urandom; s.gv = 1'($urandom); s.gap = 20'($urandom);
    end else if (pick < 18) begin
      s.active = 1; s.t = $urandom; s.spd = 17'($urandom); s.x = $urandom;
      s.y = $urandom; s.gv = 1'($urandom); s.gap = 20'($urandom);
    end else begin
      trip_t += $urandom_range(0, 400);
      pick = $urandom_range(0, 99);
      if (pick < 55) trip_spd -= $urandom_range(0, 3000);
      else if (pick < 85) trip_spd += $urandom_range(0, 1500);
      else if (pick < 95) trip_spd = $urandom_range(0, 150);
      else trip_spd = $urandom_range(20000, 100000);
      if (trip_spd < 0) trip_spd = 0;
      if (trip_spd > 100000) trip_spd = 100000;
      if ($urandom_range(0, 49) == 0) begin
        trip_x = $urandom; trip_y = $urandom;
      end else begin
        trip_x += $urandom_range(0, 6000) - 3000;
        trip_y += $urandom_range(0, 6000) - 3000;
      end
      s.active = 1; s.t = 32'(trip_t); s.spd = 17'(trip_spd); s.x = trip_x; s.y = trip_y;
      s.gv = ($urandom_range(0, 3) != 0);
      s.gap = 20'($urandom_range(0, 1) ? $urandom_range(0, 3000) :
                  $urandom_range(0, 1000000));
    end
    send_sample(s);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = phase == 0 ? 11 : phase == 1 ? 80 : 0;
      recv_idle_pct = phase == 0 ? 80 : phase == 1 ? 11 : 0;
      case (phase)
        0: write_all(-500, -200, -4000, -7000, 100, 2000, 1000);
        1: write_all(0, -100000, 0, -100000, 0, 0, 1000000);
        2: write_all(-100000, 0, -100000, 0, 100000, 32'hFFFF_FFFF, 0);
        default: write_all(-$urandom_range(0, 3000), -$urandom_range(0, 1000),
                           -$urandom_range(2000, 9000), -$urandom_range(5000, 20000),
                           $urandom_range(0, 500), $urandom_range(0, 3000),
                           $urandom_range(0, 5000));
      endcase
      if (phase == 0) begin
        send_fields(0, 5, 1000, 7, 7, 1, 5);
        send_fields(1, 0, 100000, 0, 0, 1, 1000000);
        send_fields(1, 0, 50000, 0, 0, 0, 0);
        send_fields(1, 1, 0, 0, 0, 1, 1000000);
        send_fields(1, 2, 100000, 0, 0, 1, 0);
        send_fields(1, 100, 99000, 32'h8000_0000, 32'h8000_0000, 1, 5000);
        send_fields(1, 200, 98000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 5000);
        send_fields(1, 300, 97000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 5000);
        send_fields(1, 400, 97000, 100, -100, 1, 5000);
        send_fields(1, 50, 50, 0, 0, 1, 0);
        send_fields(1, 3000, 0, 0, 0, 1, 0);
        send_fields(1, 3100, 0, 0, 0, 0, 0);
        send_fields(1, 32'hFFFF_FFFF, 200, 0, 0, 1, 1);
        send_fields(1, 32'hFFFF_FFFF, 1, 0, 0, 1, 999);
        send_fields(1, 32'hFFFF_FFFF, 1, 0, 0, 1, 998);
        send_fields(1, 32'hFFFF_FFFF, 131071, -1, -1, 1, 20'hFFFFF);
      end
      trip_t = 1000; trip_spd = 30000; trip_x = 0; trip_y = 0;
      for (int k = 0; k < RandomPerPhase; k++) random_sample();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("braking_and_stop_event_detector verification clean");
    end else begin
      $display("braking_and_stop_event_detector verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/bsed_pkg.sv
rtl/core/bsed_div.sv
rtl/core/bsed_sqrt.sv
rtl/core/braking_and_stop_event_detector.sv
tb/tb_braking_and_stop_event_detector.sv
